@@ hw/rtl/sfps_pkg.sv @@
// Shared types, widths and codes for the structure factor phase sum core.
package sfps_pkg;

  localparam int MAX_ATOMS  = 1024;
  localparam int FRAC_BITS  = 16;
  localparam int PHASE_BITS = 16;

  localparam int COORD_W = 32;
  localparam int USED_W  = 11;
  localparam int ADDR_W  = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int CNT_W   = $clog2(MAX_ATOMS + 1);

  // trig table: quadrant taken off the phase, one entry per residual angle
  localparam int TAB_AW = PHASE_BITS - 2;
  localparam int TRIG_W = 17;
  localparam int TAB_W  = 2 * TRIG_W;

  localparam int ACC_NEED = CNT_W + TRIG_W + 1;
  localparam int SUM_W    = (ACC_NEED > 33) ? ACC_NEED : 33;

  localparam logic [31:0] PI2Q = 32'hC90F_DAA2;
  localparam logic [32:0] ONEQ = 33'h0_8000_0000;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]                 mode;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0]  real_sum;
    logic signed [31:0]  imag_sum;
    logic [USED_W-1:0]   atoms_used;
    logic                load_overflow;
  } out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } atom_t;

  typedef struct packed {
    logic             start;
    logic             ack;
    logic [CNT_W-1:0] count;
  } qry_ctl_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] real_sum;
    logic signed [31:0] imag_sum;
  } qry_res_t;

endpackage

@@ hw/rtl/sfps_ram.sv @@
// Simple dual-port synchronous RAM, one write port, one registered read port.
module sfps_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/sfps_trig_init.sv @@
// Taylor series engine that fills the sine/cosine table after reset.
module sfps_trig_init import sfps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  output logic              tab_we,
  output logic [TAB_AW-1:0] tab_waddr,
  output logic [TAB_W-1:0]  tab_wdata,
  output logic              fill_done
);

  localparam int T_W   = 33;
  localparam int TERMS = 9;
  localparam int RC_W  = 38;

  // {l, ceil(2^(33+l)/d)} with l = clog2(d): exact truncating division of a 33-bit value
  function automatic logic [RC_W-1:0] recip(input int d);
    longint unsigned m;
    int              l;
    l = $clog2(d);
    m = ((64'd1 << (T_W + l)) + 64'(d) - 64'd1) / 64'(d);
    return {4'(l), 34'(m)};
  endfunction

  localparam logic [RC_W-1:0] RC_ONE = recip(1);
  localparam logic [RC_W-1:0] RC_S1  = recip(6);
  localparam logic [RC_W-1:0] RC_S2  = recip(20);
  localparam logic [RC_W-1:0] RC_S3  = recip(42);
  localparam logic [RC_W-1:0] RC_S4  = recip(72);
  localparam logic [RC_W-1:0] RC_S5  = recip(110);
  localparam logic [RC_W-1:0] RC_S6  = recip(156);
  localparam logic [RC_W-1:0] RC_S7  = recip(210);
  localparam logic [RC_W-1:0] RC_S8  = recip(272);
  localparam logic [RC_W-1:0] RC_S9  = recip(342);
  localparam logic [RC_W-1:0] RC_C1  = recip(2);
  localparam logic [RC_W-1:0] RC_C2  = recip(12);
  localparam logic [RC_W-1:0] RC_C3  = recip(30);
  localparam logic [RC_W-1:0] RC_C4  = recip(56);
  localparam logic [RC_W-1:0] RC_C5  = recip(90);
  localparam logic [RC_W-1:0] RC_C6  = recip(132);
  localparam logic [RC_W-1:0] RC_C7  = recip(182);
  localparam logic [RC_W-1:0] RC_C8  = recip(240);
  localparam logic [RC_W-1:0] RC_C9  = recip(306);

  typedef enum logic [2:0] {T_X, T_MUL_A, T_MUL_B, T_DIV, T_ACC, T_DONE} tstate_t;

  tstate_t            state_r;
  logic [TAB_AW-1:0]  r_r;
  logic [31:0]        x_r;
  logic [T_W-1:0]     t_r;
  logic signed [34:0] sum_r;
  logic [3:0]         n_r;
  logic               cos_r;
  logic [TRIG_W-1:0]  sin_q_r;
  logic [T_W-1:0]     quo_r;

  logic [T_W-1:0]     mul_a;
  logic [31:0]        mul_b;
  logic [64:0]        prod;
  logic [T_W-1:0]     qm;
  logic [31:0]        x_new;
  logic [3:0]         rsh;
  logic [33:0]        rmag;
  logic [34:0]        nm_hi;
  logic [66:0]        nm;
  logic [T_W-1:0]     quo_div;
  logic signed [34:0] term;
  logic signed [34:0] sum_upd;
  logic [31:0]        clampv;
  logic [31:0]        rnd;
  logic [TRIG_W-1:0]  q16;
  logic               last_term;

  // reciprocal of (f+1)(f+2) for term n: sine starts at f=1, cosine at f=0
  function automatic logic [RC_W-1:0] tdiv(input logic [3:0] n, input logic is_cos);
    logic [RC_W-1:0] rc;
    case ({is_cos, n})
      {1'b0, 4'd1}: rc = RC_S1;
      {1'b0, 4'd2}: rc = RC_S2;
      {1'b0, 4'd3}: rc = RC_S3;
      {1'b0, 4'd4}: rc = RC_S4;
      {1'b0, 4'd5}: rc = RC_S5;
      {1'b0, 4'd6}: rc = RC_S6;
      {1'b0, 4'd7}: rc = RC_S7;
      {1'b0, 4'd8}: rc = RC_S8;
      {1'b0, 4'd9}: rc = RC_S9;
      {1'b1, 4'd1}: rc = RC_C1;
      {1'b1, 4'd2}: rc = RC_C2;
      {1'b1, 4'd3}: rc = RC_C3;
      {1'b1, 4'd4}: rc = RC_C4;
      {1'b1, 4'd5}: rc = RC_C5;
      {1'b1, 4'd6}: rc = RC_C6;
      {1'b1, 4'd7}: rc = RC_C7;
      {1'b1, 4'd8}: rc = RC_C8;
      {1'b1, 4'd9}: rc = RC_C9;
      default:      rc = RC_ONE;
    endcase
    return rc;
  endfunction

  always_comb begin
    case (state_r)
      T_X: begin
        mul_a = T_W'(r_r);
        mul_b = PI2Q;
      end
      T_DIV: begin
        mul_a = quo_r;
        mul_b = rmag[31:0];
      end
      default: begin
        mul_a = t_r;
        mul_b = x_r;
      end
    endcase
  end

  assign prod  = 65'(mul_a) * 65'(mul_b);
  assign qm    = prod[63:31];
  assign x_new = prod[TAB_AW +: 32];

  assign {rsh, rmag} = tdiv(n_r, cos_r);
  assign nm_hi   = (rmag[33] ? {1'b0, quo_r, 1'b0} : 35'd0)
                 + (rmag[32] ? {2'b00, quo_r} : 35'd0);
  assign nm      = {2'b00, prod} + {nm_hi, 32'd0};
  assign quo_div = T_W'(nm >> (7'(T_W) + 7'(rsh)));

  assign term    = $signed({2'b00, quo_r});
  assign sum_upd = n_r[0] ? (sum_r - term) : (sum_r + term);

  always_comb begin
    if (sum_upd < 0) begin
      clampv = '0;
    end else if (sum_upd > 35'sd2147483648) begin
      clampv = 32'h8000_0000;
    end else begin
      clampv = sum_upd[31:0];
    end
  end

  assign rnd       = clampv + 32'd16384;
  assign q16       = rnd[31:15];
  assign last_term = (n_r == 4'(TERMS));

  assign tab_we    = (state_r == T_ACC) && last_term && cos_r;
  assign tab_waddr = r_r;
  assign tab_wdata = {sin_q_r, q16};
  assign fill_done = (state_r == T_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_X;
      r_r     <= '0;
    end else begin
      unique case (state_r)
        T_X: begin
          x_r     <= x_new;
          t_r     <= {1'b0, x_new};
          sum_r   <= $signed({3'b000, x_new});
          n_r     <= 4'd1;
          cos_r   <= 1'b0;
          state_r <= T_MUL_A;
        end
        T_MUL_A: begin
          t_r     <= qm;
          state_r <= T_MUL_B;
        end
        T_MUL_B: begin
          quo_r   <= qm;
          state_r <= T_DIV;
        end
        T_DIV: begin
          quo_r   <= quo_div;
          state_r <= T_ACC;
        end
        T_ACC: begin
          t_r <= quo_r;
          if (!last_term) begin
            sum_r   <= sum_upd;
            n_r     <= n_r + 4'd1;
            state_r <= T_MUL_A;
          end else if (!cos_r) begin
            sin_q_r <= q16;
            cos_r   <= 1'b1;
            n_r     <= 4'd1;
            t_r     <= ONEQ;
            sum_r   <= $signed({2'b00, ONEQ});
            state_r <= T_MUL_A;
          end else if (&r_r) begin
            state_r <= T_DONE;
          end else begin
            r_r     <= r_r + TAB_AW'(1);
            state_r <= T_X;
          end
        end
        T_DONE: begin
          state_r <= T_DONE;
        end
        default: begin
          state_r <= T_X;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/sfps_query.sv @@
// Query pipeline: walks the atom store, forms phases, looks up trig, accumulates.
module sfps_query import sfps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  qry_ctl_t          ctl,
  input  in_t               req,
  output logic              atom_re,
  output logic [ADDR_W-1:0] atom_raddr,
  input  atom_t             atom_q,
  output logic              tab_re,
  output logic [TAB_AW-1:0] tab_raddr,
  input  logic [TAB_W-1:0]  tab_q,
  output qry_res_t          res
);

  localparam int PH_SHR = (2 * FRAC_BITS >= PHASE_BITS) ? 2 * FRAC_BITS - PHASE_BITS : 0;
  localparam int PH_SHL = (2 * FRAC_BITS >= PHASE_BITS) ? 0 : PHASE_BITS - 2 * FRAC_BITS;

  logic                      run_r;
  logic [CNT_W-1:0]          idx_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [COORD_W-1:0] gx_r;
  logic signed [COORD_W-1:0] gy_r;
  logic signed [COORD_W-1:0] gz_r;
  logic                      v1_r;
  logic                      v2_r;
  logic                      v3_r;
  logic [63:0]               px_r;
  logic [63:0]               py_r;
  logic [63:0]               pz_r;
  logic [1:0]                quad_r;
  logic signed [SUM_W-1:0]   acc_re_r;
  logic signed [SUM_W-1:0]   acc_im_r;

  logic                      issue;
  logic [63:0]               dsum;
  logic [PHASE_BITS-1:0]     phase;
  logic signed [TRIG_W:0]    s0;
  logic signed [TRIG_W:0]    c0;
  logic signed [TRIG_W:0]    dre;
  logic signed [TRIG_W:0]    dim;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-32:0] hi;
    hi = v[SUM_W-1:31];
    if (hi == '0 || hi == '1) begin
      return v[31:0];
    end else if (v[SUM_W-1]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7FFF_FFFF;
    end
  endfunction

  assign issue      = run_r && (idx_r != cnt_r);
  assign atom_re    = issue;
  assign atom_raddr = idx_r[ADDR_W-1:0];

  // phase in turns: fractional bits of g.tau, products wrap modulo 2^64
  assign dsum      = px_r + py_r + pz_r;
  assign phase     = PHASE_BITS'((dsum >> PH_SHR) << PH_SHL);
  assign tab_re    = v2_r;
  assign tab_raddr = phase[TAB_AW-1:0];

  assign s0 = $signed({1'b0, tab_q[TAB_W-1 -: TRIG_W]});
  assign c0 = $signed({1'b0, tab_q[TRIG_W-1:0]});

  always_comb begin
    case (quad_r)
      2'd0:    begin dre = c0;  dim = -s0; end
      2'd1:    begin dre = -s0; dim = -c0; end
      2'd2:    begin dre = -c0; dim = s0;  end
      default: begin dre = s0;  dim = c0;  end
    endcase
  end

  assign res.done     = run_r && !issue && !(v1_r || v2_r || v3_r);
  assign res.real_sum = sat32(acc_re_r);
  assign res.imag_sum = sat32(acc_im_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (ctl.start) begin
        run_r <= 1'b1;
      end else if (ctl.ack) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      idx_r <= '0;
      cnt_r <= ctl.count;
      gx_r  <= req.coord_x;
      gy_r  <= req.coord_y;
      gz_r  <= req.coord_z;
    end else if (issue) begin
      idx_r <= idx_r + CNT_W'(1);
    end
    if (v1_r) begin
      px_r <= gx_r * atom_q.x;
      py_r <= gy_r * atom_q.y;
      pz_r <= gz_r * atom_q.z;
    end
    if (v2_r) begin
      quad_r <= phase[PHASE_BITS-1 -: 2];
    end
    if (ctl.start) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (v3_r) begin
      acc_re_r <= acc_re_r + SUM_W'(dre);
      acc_im_r <= acc_im_r + SUM_W'(dim);
    end
  end

endmodule

@@ hw/rtl/structure_factor_phase_sum_core.sv @@
// Structure factor phase sum core: atom store, trig table, control and result register.
//
// Input channel in_valid/in_stall/in_data carries one transaction per item. mode 0
// appends an atom position to the store (dropped and flagged when the store is full),
// mode 2 empties the store, mode 1 carries a reciprocal vector g and produces one
// result on out_valid/out_stall/out_data: the saturated real and imaginary sums of
// exp(-i*2*pi*(g.tau)) over the stored atoms, the atom count and the overflow flag.
// Mode 3 is ignored.
// Load and clear may follow each other every cycle while the core is idle.
// A query walks the store one atom per cycle through the atom RAM read port;
// out_valid rises once the pipeline has drained and the result register is free,
// and in_stall falls in the same cycle.
// The result register holds a finished result while out_stall is high; loads and
// clears are still taken meanwhile, and a later query finishes only once the
// register is free.
// After reset the sine/cosine table is filled by the Taylor engine, one entry at a
// time over 2^(PHASE_BITS-2) entries, with in_stall held high. Reset also empties
// the atom store and clears the overflow flag.
module structure_factor_phase_sum_core import sfps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  typedef enum logic [1:0] {ST_INIT, ST_IDLE, ST_QUERY} state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  logic             ovf_r;
  logic             out_valid_r;
  out_t             out_data_r;

  logic              in_acc;
  logic              has_room;
  logic              out_free;
  logic              atom_we;
  atom_t             atom_wdata;
  logic              atom_re;
  logic [ADDR_W-1:0] atom_raddr;
  atom_t             atom_q;
  logic              tab_we;
  logic [TAB_AW-1:0] tab_waddr;
  logic [TAB_W-1:0]  tab_wdata;
  logic              tab_re;
  logic [TAB_AW-1:0] tab_raddr;
  logic [TAB_W-1:0]  tab_q;
  logic              fill_done;
  qry_ctl_t          qctl;
  qry_res_t          qres;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign has_room = count_r < CNT_W'(MAX_ATOMS);
  assign out_free = !out_valid_r || !out_stall;

  assign atom_we      = in_acc && (in_data.mode == MODE_LOAD) && has_room;
  assign atom_wdata.x = in_data.coord_x;
  assign atom_wdata.y = in_data.coord_y;
  assign atom_wdata.z = in_data.coord_z;

  assign qctl.start = in_acc && (in_data.mode == MODE_QUERY);
  assign qctl.ack   = (state_r == ST_QUERY) && qres.done && out_free;
  assign qctl.count = count_r;

  sfps_ram #(
    .DEPTH (MAX_ATOMS),
    .WIDTH ($bits(atom_t))
  ) u_atom_ram (
    .clk   (clk),
    .we    (atom_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (atom_wdata),
    .re    (atom_re),
    .raddr (atom_raddr),
    .rdata (atom_q)
  );

  sfps_ram #(
    .DEPTH (2 ** TAB_AW),
    .WIDTH (TAB_W)
  ) u_trig_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .re    (tab_re),
    .raddr (tab_raddr),
    .rdata (tab_q)
  );

  sfps_trig_init u_trig_init (
    .clk       (clk),
    .rst_n     (rst_n),
    .tab_we    (tab_we),
    .tab_waddr (tab_waddr),
    .tab_wdata (tab_wdata),
    .fill_done (fill_done)
  );

  sfps_query u_query (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (qctl),
    .req        (in_data),
    .atom_re    (atom_re),
    .atom_raddr (atom_raddr),
    .atom_q     (atom_q),
    .tab_re     (tab_re),
    .tab_raddr  (tab_raddr),
    .tab_q      (tab_q),
    .res        (qres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (qctl.ack) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_INIT: begin
          if (fill_done) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            unique case (in_data.mode)
              MODE_LOAD: begin
                if (has_room) begin
                  count_r <= count_r + CNT_W'(1);
                end else begin
                  ovf_r <= 1'b1;
                end
              end
              MODE_QUERY: begin
                state_r <= ST_QUERY;
              end
              MODE_CLEAR: begin
                count_r <= '0;
                ovf_r   <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_QUERY: begin
          if (qctl.ack) begin
            out_data_r.real_sum      <= qres.real_sum;
            out_data_r.imag_sum      <= qres.imag_sum;
            out_data_r.atoms_used    <= USED_W'(count_r);
            out_data_r.load_overflow <= ovf_r;
            state_r                  <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_INIT;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_full_load_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.mode == MODE_LOAD && count_r == CNT_W'(MAX_ATOMS)) |=> ovf_r)
    else $error("load into full store did not set overflow");

  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_QUERY))
    else $error("result raised outside a query");

  a_done_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    qres.done |-> state_r == ST_QUERY)
    else $error("query pipeline finished outside a query");

  a_count_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(in_acc) |-> $stable(count_r))
    else $error("atom count changed without a transaction");

endmodule
